### sv/tccw_pkg.sv
`timescale 1ns / 1ps
// tccw_pkg: shared types, constants and helpers for the text console cursor writer
// no dependencies

package tccw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    // row reaches ROWS when it runs off the screen, so it needs room for that value
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int CELL_W = 11;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // operation codes
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_DEL   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // register indexes
    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    localparam logic [3:0] FG_RESET = 4'd15;
    localparam logic [3:0] BG_RESET = 4'd0;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
    } t_in_beat;

    typedef struct packed {
        logic              write_enable;
        logic [CELL_W-1:0] cell_index;
        logic [7:0]        char_out;
        logic [7:0]        attr_out;
        logic              clear_all;
        logic [CELL_W-1:0] cursor_pos;
    } t_out_beat;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_cursor;

    // linear cell number, wrapped to the output width
    function automatic logic [CELL_W-1:0] cell_of(input t_cursor cur);
        logic [CELL_W+ROW_W-1:0] prod;
        prod = (CELL_W+ROW_W)'(cur.row) * (CELL_W+ROW_W)'(COLUMNS)
             + (CELL_W+ROW_W)'(cur.col);
        return prod[CELL_W-1:0];
    endfunction

endpackage

### sv/tccw_step.sv
`timescale 1ns / 1ps
// tccw_step: next cursor and result beat for one operation
// depends on tccw_pkg

module tccw_step
    import tccw_pkg::*;
(
    input  t_in_beat   i_beat,
    input  t_cursor    i_cur,
    input  logic [7:0] i_attr,
    output t_cursor    o_cur,
    output t_out_beat  o_beat
);

    t_cursor  cur_n;
    t_cursor  wr_cur;
    logic     we;
    logic     clr;
    logic [7:0] ch;

    always_comb begin
        cur_n  = i_cur;
        wr_cur = i_cur;
        we     = 1'b0;
        clr    = 1'b0;
        ch     = 8'd0;
        unique case (i_beat.func)
            FUNC_PUT: begin
                if (i_beat.char_code == NEWLINE_CODE) begin
                    cur_n.col = '0;
                    if (i_cur.row < ROW_W'(ROWS)) begin
                        cur_n.row = i_cur.row + ROW_W'(1);
                    end
                end else if (i_cur.row < ROW_W'(ROWS)) begin
                    we = 1'b1;
                    ch = i_beat.char_code;
                    if (i_cur.col == COL_W'(COLUMNS - 1)) begin
                        cur_n.col = '0;
                        cur_n.row = i_cur.row + ROW_W'(1);
                    end else begin
                        cur_n.col = i_cur.col + COL_W'(1);
                    end
                end
            end
            FUNC_DEL: begin
                if (i_cur.row != '0 || i_cur.col != '0) begin
                    if (i_cur.col == '0) begin
                        cur_n.col = COL_W'(COLUMNS - 1);
                        cur_n.row = i_cur.row - ROW_W'(1);
                    end else begin
                        cur_n.col = i_cur.col - COL_W'(1);
                    end
                    we     = 1'b1;
                    wr_cur = cur_n;
                end
            end
            FUNC_CLEAR: begin
                cur_n = '0;
                clr   = 1'b1;
            end
            default: begin
                // unused code leaves everything alone
                cur_n = i_cur;
            end
        endcase
    end

    assign o_cur = cur_n;

    always_comb begin
        o_beat              = '0;
        o_beat.write_enable = we;
        o_beat.cell_index   = we ? cell_of(wr_cur) : '0;
        o_beat.char_out     = we ? ch : 8'd0;
        o_beat.attr_out     = we ? i_attr : 8'd0;
        o_beat.clear_all    = clr;
        o_beat.cursor_pos   = cell_of(cur_n);
    end

endmodule

### sv/text_console_cursor_writer.sv
`timescale 1ns / 1ps
// text_console_cursor_writer: top level, input and result registers, cursor and color state
// depends on tccw_pkg and tccw_step

// Takes one operation beat per cycle (put character, delete, clear) unless the result side
// stalls, and returns one result beat per operation, carrying the cell write (if any), the
// clear request and the new cursor position. The accepting edge loads the input register;
// the result register is loaded from it once the result register is free. The cursor update
// is combinational between those registers, so back-to-back beats see each other's cursor.
// The user writes colors on the config port only while no beat is in flight; the block
// itself does not enforce this.

module text_console_cursor_writer
    import tccw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;
    t_cursor   r_cur;
    logic [3:0] r_fg;
    logic [3:0] r_bg;

    t_cursor   n_cur;
    t_out_beat n_out;
    logic      out_free;
    logic      fire;

    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    tccw_step u_step (
        .i_beat (r_in),
        .i_cur  (r_cur),
        .i_attr ({r_bg, r_fg}),
        .o_cur  (n_cur),
        .o_beat (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur       <= '0;
            r_fg        <= FG_RESET;
            r_bg        <= BG_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_cur <= n_cur;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FG: r_fg <= i_cfg_data;
                    CFG_BG: r_bg <= i_cfg_data;
                    default: r_fg <= r_fg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // cursor never leaves its legal range
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur.row <= ROW_W'(ROWS)) && (r_cur.col < COL_W'(COLUMNS)))
        else $error("cursor out of range");

    // a clear never comes with a cell write and always homes the cursor
    a_clear_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.clear_all) |->
            (!r_out.write_enable && r_out.cursor_pos == '0))
        else $error("clear beat not homed or also writing");

    // no write means zeroed write fields
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.write_enable) |->
            (r_out.cell_index == '0 && r_out.char_out == 8'd0 && r_out.attr_out == 8'd0))
        else $error("write fields set without a write");

    // reported cursor follows the cursor state after each step
    a_cursor_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_out.cursor_pos == cell_of(r_cur)))
        else $error("result cursor does not match cursor state");

endmodule

### tb/console_writer_checker.sv
`timescale 1ns / 1ps
// console_writer_checker: watches the operation, result and color ports of the console writer,
// keeps its own cursor and colors, predicts each result beat and compares it field by field
// depends on tccw_pkg

module console_writer_checker
    import tccw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_beat   i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_beat  i_out_data,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [3:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    // cursor row runs 0..ROWS, ROWS meaning off the bottom of the screen
    int         row;
    int         col;
    logic [3:0] fg;
    logic [3:0] bg;
    t_out_beat  screen_updates_q[$];
    int         fails;

    assign o_fail_count = fails;

    function automatic t_out_beat predict_screen_update(input t_in_beat op);
        t_out_beat upd;
        upd = '0;
        case (op.func)
            FUNC_PUT: begin
                if (op.char_code == NEWLINE_CODE) begin
                    col = 0;
                    if (row < ROWS)
                        row++;
                end else if (row < ROWS) begin
                    upd.write_enable = 1'b1;
                    upd.cell_index   = CELL_W'(row * COLUMNS + col);
                    upd.char_out     = op.char_code;
                    col++;
                    if (col >= COLUMNS) begin
                        col = 0;
                        row++;
                    end
                end
            end
            FUNC_DEL: begin
                if (row != 0 || col != 0) begin
                    if (col == 0) begin
                        col = COLUMNS - 1;
                        row--;
                    end else begin
                        col--;
                    end
                    upd.write_enable = 1'b1;
                    upd.cell_index   = CELL_W'(row * COLUMNS + col);
                    upd.char_out     = 8'h00;
                end
            end
            FUNC_CLEAR: begin
                row = 0;
                col = 0;
                upd.clear_all = 1'b1;
            end
            default: begin
            end
        endcase
        if (upd.write_enable)
            upd.attr_out = {bg, fg};
        upd.cursor_pos = CELL_W'(row * COLUMNS + col);
        return upd;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            fails++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            row = 0;
            col = 0;
            fg  = FG_RESET;
            bg  = BG_RESET;
            screen_updates_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FG)
                    fg = i_cfg_data;
                else
                    bg = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (screen_updates_q.size() == 0) begin
                    fails++;
                    $error("result beat arrived with no operation outstanding");
                end else begin
                    want = screen_updates_q.pop_front();
                    check_field("write_enable", want.write_enable, i_out_data.write_enable);
                    check_field("cell_index", want.cell_index, i_out_data.cell_index);
                    check_field("char_out", want.char_out, i_out_data.char_out);
                    check_field("attr_out", want.attr_out, i_out_data.attr_out);
                    check_field("clear_all", want.clear_all, i_out_data.clear_all);
                    check_field("cursor_pos", want.cursor_pos, i_out_data.cursor_pos);
                end
            end
            if (i_in_valid && i_in_ready)
                screen_updates_q.push_back(predict_screen_update(i_in_data));
        end
        o_pending <= screen_updates_q.size();
    end

endmodule

### tb/text_console_cursor_writer_tb.sv
`timescale 1ns / 1ps
// text_console_cursor_writer_tb: clock, reset, operation stimulus, color writes and verdict
// depends on tccw_pkg, text_console_cursor_writer and console_writer_checker

module text_console_cursor_writer_tb;
    import tccw_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int PHASES          = 5;
    localparam int PHASE_BEATS     = 120;
    localparam int IDLE_PCT        = 19;
    localparam int RX_STALL_CYCLES = 64;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_beat   i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_beat  o_out_data;
    logic       i_cfg_we;
    logic       i_cfg_index;
    logic [3:0] i_cfg_data;

    int fail_count;
    int pending;
    bit tx_idle_on;
    bit rx_idle_on;
    int stall_asks;
    int stalls_served;
    int beats_counted;
    int n_total, n_put, n_newline, n_del, n_clear, n_unused, n_settings;

    text_console_cursor_writer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    console_writer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // offer one operation beat and return at the edge where it is taken, valid still high
    task automatic send_op(input logic [1:0] func, input logic [7:0] ch);
        int gap;
        gap = 0;
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= {func, ch};
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        n_total++;
        case (func)
            FUNC_PUT: begin
                if (ch == NEWLINE_CODE)
                    n_newline++;
                else
                    n_put++;
            end
            FUNC_DEL:   n_del++;
            FUNC_CLEAR: n_clear++;
            default:    n_unused++;
        endcase
        if (func != FUNC_UNUSED)
            beats_counted++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_color(input logic idx, input logic [3:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic set_colors(input int phase);
        logic [3:0] fg;
        logic [3:0] bg;
        case (phase)
            1:       begin fg = 4'd0;  bg = 4'd15; end
            2:       begin fg = 4'd15; bg = 4'd15; end
            3:       begin fg = 4'd0;  bg = 4'd0;  end
            default: begin fg = 4'($urandom_range(15)); bg = 4'($urandom_range(15)); end
        endcase
        write_color(CFG_FG, fg);
        write_color(CFG_BG, bg);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic run_directed();
        send_op(FUNC_DEL, 8'h00);        // delete with the cursor at cell zero
        send_op(FUNC_UNUSED, 8'hFF);
        send_op(FUNC_PUT, 8'h00);
        send_op(FUNC_PUT, 8'hFF);
        send_op(FUNC_PUT, NEWLINE_CODE - 8'd1);
        send_op(FUNC_PUT, NEWLINE_CODE + 8'd1);
        send_op(FUNC_PUT, NEWLINE_CODE);
        send_op(FUNC_DEL, 8'hFF);        // column zero, wraps to the last column above
        send_op(FUNC_PUT, 8'h55);        // written in the last column, wraps to next row
        send_op(FUNC_PUT, 8'hAA);
        send_op(FUNC_DEL, 8'h00);
        send_op(FUNC_CLEAR, 8'hFF);
        send_op(FUNC_UNUSED, 8'h00);
        send_op(FUNC_PUT, NEWLINE_CODE);
        send_op(FUNC_PUT, NEWLINE_CODE);
        send_op(FUNC_PUT, 8'h7F);
        send_op(FUNC_DEL, 8'h80);
        send_op(FUNC_CLEAR, 8'h00);
    endtask

    // run off the screen, try to print there, then back up across the last row
    task automatic run_off_bottom();
        repeat (ROWS + 1) send_op(FUNC_PUT, NEWLINE_CODE);
        repeat ($urandom_range(1, 4)) send_op(FUNC_PUT, 8'($urandom_range(255)));
        send_op(FUNC_PUT, NEWLINE_CODE);
        repeat ($urandom_range(1, 3)) send_op(FUNC_DEL, 8'($urandom_range(255)));
        repeat ($urandom_range(1, 5)) send_op(FUNC_PUT, 8'($urandom_range(255)));
    endtask

    task automatic run_sequence();
        int kind;
        kind = $urandom_range(99);
        if (kind < 38) begin
            // a line of text, long enough at times to wrap
            repeat ($urandom_range(1, 90)) send_op(FUNC_PUT, 8'($urandom_range(255)));
            if ($urandom_range(1) == 1)
                send_op(FUNC_PUT, NEWLINE_CODE);
        end else if (kind < 52) begin
            repeat ($urandom_range(1, 30)) send_op(FUNC_PUT, NEWLINE_CODE);
        end else if (kind < 68) begin
            repeat ($urandom_range(1, 100)) send_op(FUNC_DEL, 8'($urandom_range(255)));
        end else if (kind < 78) begin
            run_off_bottom();
        end else if (kind < 88) begin
            send_op(FUNC_CLEAR, 8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 12))
                send_op(2'($urandom_range(3)), 8'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input bit force_bottom, input bit with_stall);
        int  start;
        bit  stalled;
        start   = beats_counted;
        stalled = 1'b0;
        if (force_bottom)
            run_off_bottom();
        while (beats_counted - start < PHASE_BEATS) begin
            if (with_stall && !stalled && beats_counted - start >= PHASE_BEATS / 2) begin
                // receiver holds off while we keep offering beats
                stall_asks <= stall_asks + 1;
                stalled = 1'b1;
            end
            run_sequence();
        end
    endtask

    // receiver
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_asks != stalls_served) begin
                i_out_ready <= 1'b0;
                repeat (RX_STALL_CYCLES) @(posedge i_clk);
                stalls_served++;
            end
            i_out_ready <= !(rx_idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog on beats moving on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no beat moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_FG;
        i_cfg_data  <= '0;
        rx_idle_on  <= 1'b1;
        tx_idle_on  = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset colors in force for the directed beats and the first phase
        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            drain();
            if (p > 0)
                set_colors(p);
            tx_idle_on = (p != 2);
            rx_idle_on <= (p != 2);
            run_phase(p == 0, p == 1 || p == 3);
        end
        drain();
        repeat (8) @(posedge i_clk);

        $display("run covered %0d beats: %0d puts, %0d newlines, %0d deletes, %0d clears, %0d unused",
                 n_total, n_put, n_newline, n_del, n_clear, n_unused);
        $display("over %0d color settings, with receiver stalls and a stretch without idle cycles",
                 n_settings + 1);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### text_console_cursor_writer.f
sv/tccw_pkg.sv
sv/tccw_step.sv
sv/text_console_cursor_writer.sv
tb/console_writer_checker.sv
tb/text_console_cursor_writer_tb.sv
